>>> design/digram_text_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// Digram text decoder assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DIGRAM_TEXT_DECODER_TOP_DEFINES_SVH
`define DIGRAM_TEXT_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define DTD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/dtd_pkg.sv
// ----------------------------------------------------------------------------
// Digram text decoder package
// Codes, operation type, queue sizing and character tables.
// ----------------------------------------------------------------------------
package dtd_pkg;

	localparam logic [7:0] ESCAPE_CODE   = 8'h1B;
	localparam logic [7:0] ESC_OFFSET    = 8'h7F;
	localparam logic [7:0] CR_CODE       = 8'h0D;
	localparam logic [7:0] FF_CODE       = 8'h0C;
	localparam logic [7:0] NEWLINE_CHAR  = 8'h0A;
	localparam logic [7:0] PERIOD_CODE   = 8'h1F;
	localparam logic [7:0] PERIOD_CHAR   = 8'h2E;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		OP_CHAR,
		OP_DIGRAM,
		OP_ERROR
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data;
		logic       str_end;
	} op_t;

	localparam logic [7:0] LEAD_CHARS [16] = '{
		8'h20, 8'h65, 8'h74, 8'h61, 8'h69, 8'h6E, 8'h6F, 8'h73,
		8'h72, 8'h6C, 8'h68, 8'h63, 8'h64, 8'h75, 8'h70, 8'h6D
	};

	localparam logic [7:0] FOLLOW_CHARS [16][8] = '{
		'{8'h74, 8'h61, 8'h73, 8'h69, 8'h6F, 8'h20, 8'h77, 8'h62},
		'{8'h20, 8'h72, 8'h6E, 8'h73, 8'h64, 8'h61, 8'h6C, 8'h6D},
		'{8'h68, 8'h20, 8'h69, 8'h65, 8'h6F, 8'h72, 8'h61, 8'h73},
		'{8'h6E, 8'h72, 8'h74, 8'h6C, 8'h63, 8'h20, 8'h73, 8'h79},
		'{8'h6E, 8'h73, 8'h74, 8'h63, 8'h6C, 8'h6F, 8'h65, 8'h72},
		'{8'h20, 8'h64, 8'h74, 8'h67, 8'h65, 8'h73, 8'h69, 8'h6F},
		'{8'h6E, 8'h72, 8'h20, 8'h75, 8'h66, 8'h6D, 8'h73, 8'h77},
		'{8'h20, 8'h74, 8'h65, 8'h70, 8'h2E, 8'h69, 8'h63, 8'h61},
		'{8'h65, 8'h20, 8'h6F, 8'h69, 8'h61, 8'h64, 8'h75, 8'h72},
		'{8'h20, 8'h6C, 8'h61, 8'h65, 8'h69, 8'h79, 8'h6F, 8'h64},
		'{8'h65, 8'h69, 8'h61, 8'h20, 8'h6F, 8'h74, 8'h72, 8'h75},
		'{8'h65, 8'h74, 8'h6F, 8'h61, 8'h6B, 8'h68, 8'h6C, 8'h72},
		'{8'h20, 8'h65, 8'h69, 8'h75, 8'h2C, 8'h2E, 8'h6F, 8'h61},
		'{8'h6E, 8'h73, 8'h72, 8'h63, 8'h74, 8'h6C, 8'h61, 8'h69},
		'{8'h6C, 8'h65, 8'h6F, 8'h69, 8'h72, 8'h61, 8'h74, 8'h70},
		'{8'h65, 8'h61, 8'h6F, 8'h69, 8'h70, 8'h20, 8'h62, 8'h6D}
	};

endpackage

>>> design/dtd_in_if.sv
// ----------------------------------------------------------------------------
// Code byte stream interface
// Valid/ready channel carrying one compressed byte and its end flag.
// ----------------------------------------------------------------------------
interface dtd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       string_end;

	modport source (output valid, code_byte, string_end, input ready);
	modport sink   (input valid, code_byte, string_end, output ready);
endinterface

>>> design/dtd_out_if.sv
// ----------------------------------------------------------------------------
// Character stream interface
// Valid/ready channel carrying one decoded character and its flags.
// ----------------------------------------------------------------------------
interface dtd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       run_last;
	logic       text_end;
	logic       escape_error;

	modport source (output valid, char_out, run_last, text_end, escape_error, input ready);
	modport sink   (input valid, char_out, run_last, text_end, escape_error, output ready);
endinterface

>>> design/dtd_op_if.sv
// ----------------------------------------------------------------------------
// Operation stream interface
// Internal valid/ready channel carrying classified decode operations.
// ----------------------------------------------------------------------------
interface dtd_op_if import dtd_pkg::*;;
	logic valid;
	logic ready;
	op_t  op;

	modport source (output valid, op, input ready);
	modport sink   (input valid, op, output ready);
endinterface

>>> design/digram_text_decoder_top.sv
// ----------------------------------------------------------------------------
// Digram text decoder top level
// Expands a compressed text string into character bytes.
// ----------------------------------------------------------------------------
// Each code byte on in_stream is turned into zero, one or two characters on
// out_stream. A plain or escaped byte gives one character, a digram byte (bit
// 7 set) gives two, and an escape inside a string gives none; the single
// output register emits one character per cycle while out_stream is ready.
// A four-entry operation queue between the front end and the back end lets
// input transfers continue while output is stalled.
module digram_text_decoder_top import dtd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	dtd_in_if.sink    in_stream,
	dtd_out_if.source out_stream
);

	dtd_op_if front_op ();
	dtd_op_if back_op ();

	dtd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_stream (in_stream),
		.op_stream (front_op.source)
	);

	dtd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_op.sink),
		.pop    (back_op.source)
	);

	dtd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_stream  (back_op.sink),
		.out_stream (out_stream)
	);

endmodule

>>> design/dtd_front.sv
// ----------------------------------------------------------------------------
// Digram text decoder front end
// Accepts code bytes, tracks escapes and turns each other byte into an operation.
// ----------------------------------------------------------------------------
module dtd_front import dtd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	dtd_in_if.sink       in_stream,
	dtd_op_if.source     op_stream
);

	logic       escape_pending_q;
	logic       accept;
	logic       hold_escape;
	logic [7:0] plain_char;

	always_comb begin
		unique case (in_stream.code_byte)
			CR_CODE, FF_CODE: plain_char = NEWLINE_CHAR;
			PERIOD_CODE:      plain_char = PERIOD_CHAR;
			default:          plain_char = in_stream.code_byte;
		endcase
	end

	assign hold_escape = !escape_pending_q && !in_stream.code_byte[7] &&
		(in_stream.code_byte == ESCAPE_CODE) && !in_stream.string_end;

	always_comb begin
		op_stream.op.str_end = in_stream.string_end;
		if (escape_pending_q) begin
			op_stream.op.kind = OP_CHAR;
			op_stream.op.data = in_stream.code_byte + ESC_OFFSET;
		end else if (in_stream.code_byte[7]) begin
			op_stream.op.kind = OP_DIGRAM;
			op_stream.op.data = in_stream.code_byte;
		end else if (in_stream.code_byte == ESCAPE_CODE) begin
			op_stream.op.kind = OP_ERROR;
			op_stream.op.data = '0;
		end else begin
			op_stream.op.kind = OP_CHAR;
			op_stream.op.data = plain_char;
		end
	end

	assign in_stream.ready = op_stream.ready;
	assign op_stream.valid = in_stream.valid && !hold_escape;
	assign accept          = in_stream.valid && in_stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_pending_q <= 1'b0;
		end else if (accept) begin
			escape_pending_q <= hold_escape;
		end
	end

endmodule

>>> design/dtd_queue.sv
// ----------------------------------------------------------------------------
// Digram text decoder operation queue
// Small FIFO that decouples classification from character emission.
// ----------------------------------------------------------------------------
module dtd_queue import dtd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	dtd_op_if.sink   push,
	dtd_op_if.source pop
);

	op_t               mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push.ready = (count_q != QCNT_W'(QDEPTH));
	assign pop.valid  = (count_q != '0);
	assign pop.op     = mem[rd_ptr_q];
	assign do_push    = push.valid && push.ready;
	assign do_pop     = pop.valid && pop.ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push.op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/dtd_back.sv
// ----------------------------------------------------------------------------
// Digram text decoder back end
// Expands operations into characters and holds them in the output register.
// ----------------------------------------------------------------------------
module dtd_back import dtd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dtd_op_if.sink     op_stream,
	dtd_out_if.source  out_stream
);

	logic       out_valid_q;
	logic       phase_q;
	logic       take;
	logic       load;
	logic [3:0] hi;
	logic [2:0] lo;
	logic [7:0] char_q;
	logic       last_q;
	logic       end_q;
	logic       err_q;

	assign hi   = op_stream.op.data[6:3];
	assign lo   = op_stream.op.data[2:0];
	assign take = !out_valid_q || out_stream.ready;
	assign load = take && op_stream.valid;

	assign op_stream.ready = take && ((op_stream.op.kind != OP_DIGRAM) || phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (take) begin
			out_valid_q <= op_stream.valid;
			if (op_stream.valid && (op_stream.op.kind == OP_DIGRAM)) begin
				phase_q <= !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unique case (op_stream.op.kind)
				OP_CHAR: begin
					char_q <= op_stream.op.data;
					last_q <= 1'b1;
					end_q  <= op_stream.op.str_end;
					err_q  <= 1'b0;
				end
				OP_DIGRAM: begin
					char_q <= phase_q ? FOLLOW_CHARS[hi][lo] : LEAD_CHARS[hi];
					last_q <= phase_q;
					end_q  <= phase_q && op_stream.op.str_end;
					err_q  <= 1'b0;
				end
				OP_ERROR: begin
					char_q <= '0;
					last_q <= 1'b1;
					end_q  <= 1'b1;
					err_q  <= 1'b1;
				end
				default: begin
					char_q <= '0;
					last_q <= 1'b1;
					end_q  <= 1'b1;
					err_q  <= 1'b1;
				end
			endcase
		end
	end

	assign out_stream.valid        = out_valid_q;
	assign out_stream.char_out     = char_q;
	assign out_stream.run_last     = last_q;
	assign out_stream.text_end     = end_q;
	assign out_stream.escape_error = err_q;

endmodule

>>> design/dtd_checker.sv
// ----------------------------------------------------------------------------
// Digram text decoder port checker
// Checks result flag consistency and output transfer ordering at the ports.
// ----------------------------------------------------------------------------
`include "digram_text_decoder_top_defines.svh"

module dtd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] char_out,
	input logic       run_last,
	input logic       text_end,
	input logic       escape_error
);

	`DTD_ASSERT_SAME(a_error_form, out_valid && escape_error, (char_out == 8'h00) && run_last && text_end, "malformed error result")

	`DTD_ASSERT_SAME(a_first_half_flags, out_valid && !run_last, !text_end && !escape_error, "first digram character carries end flags")

	`DTD_ASSERT_NEXT(a_second_half_follows, out_valid && out_ready && !run_last, out_valid && run_last, "second digram character missing")

	`DTD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(char_out) && $stable(run_last) && $stable(text_end) && $stable(escape_error), "stalled result changed")

endmodule

bind digram_text_decoder_top dtd_checker u_dtd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_stream.valid),
	.out_ready    (out_stream.ready),
	.char_out     (out_stream.char_out),
	.run_last     (out_stream.run_last),
	.text_end     (out_stream.text_end),
	.escape_error (out_stream.escape_error)
);

>>> sim/digram_text_decoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Digram text decoder testbench
// Streams compressed text strings into the decoder with random gaps and
// random output stalls. An in-bench decoder predicts every character, and
// each result transfer is checked field by field in order.
// ----------------------------------------------------------------------------
module digram_text_decoder_top_test;
	import dtd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned CODE_TARGET = 1550;
	localparam int unsigned SETTLE_CYCLES = 20;

	localparam logic [127:0] LEAD_ROW = " etainosrlhcdupm";
	localparam logic [63:0] FOLLOW_ROWS [16] = '{
		"tasio wb", " rnsdalm", "h ieoras", "nrtlc sy",
		"nstcloer", " dtgesio", "nr ufmsw", " tep.ica",
		"e oiadur", " laeiyod", "eia otru", "etoakhlr",
		" eiu,.oa", "nsrctlai", "leoiratp", "eaoip bm"
	};

	typedef struct {
		logic [7:0]  code;
		logic        last;
		int unsigned gap;
		logic        drain;
	} code_item_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       run_last;
		logic       text_end;
		logic       escape_error;
	} char_result_t;

	logic clk;
	logic arst_n = 1'b0;

	dtd_in_if  in_bus ();
	dtd_out_if out_bus ();

	digram_text_decoder_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_stream  (in_bus),
		.out_stream (out_bus)
	);

	code_item_t   pending_codes [$];
	char_result_t expected_chars [$];
	logic         escape_armed;
	int unsigned  idle_left;
	int unsigned  stall_left;
	int unsigned  cycle_count;
	int unsigned  failures;
	int unsigned  codes_sent;
	int unsigned  strings_sent;
	int unsigned  chars_checked;
	int unsigned  digrams_seen;
	int unsigned  escape_errors;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic void expect_char(input logic [7:0] ch, input logic run_last,
			input logic text_end, input logic escape_error);
		expected_chars.push_back(char_result_t'{ch, run_last, text_end, escape_error});
	endfunction

	function automatic void expand_code(input logic [7:0] code, input logic last);
		logic [3:0] row;
		logic [2:0] col;
		logic [7:0] ch;
		row = code[6:3];
		col = code[2:0];
		codes_sent++;
		if (last)
			strings_sent++;
		if (escape_armed) begin
			escape_armed = 1'b0;
			ch = code + ESC_OFFSET;
			expect_char(ch, 1'b1, last, 1'b0);
		end else if (code[7]) begin
			digrams_seen++;
			expect_char(LEAD_ROW[8 * (15 - row) +: 8], 1'b0, 1'b0, 1'b0);
			expect_char(FOLLOW_ROWS[row][8 * (7 - col) +: 8], 1'b1, last, 1'b0);
		end else if (code == ESCAPE_CODE) begin
			if (last) begin
				escape_errors++;
				expect_char(8'h00, 1'b1, 1'b1, 1'b1);
			end else begin
				escape_armed = 1'b1;
			end
		end else begin
			if (code == CR_CODE || code == FF_CODE)
				ch = NEWLINE_CHAR;
			else if (code == PERIOD_CODE)
				ch = PERIOD_CHAR;
			else
				ch = code;
			expect_char(ch, 1'b1, last, 1'b0);
		end
	endfunction

	task automatic add_code(input logic [7:0] code, input logic last, input int unsigned gap,
			input logic drain);
		pending_codes.push_back('{code, last, gap, drain});
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		code_item_t next_code;
		if (!arst_n) begin
			in_bus.valid <= 1'b0;
			in_bus.code_byte <= 8'h00;
			in_bus.string_end <= 1'b0;
			idle_left <= 0;
		end else begin
			if (in_bus.valid && in_bus.ready)
				expand_code(in_bus.code_byte, in_bus.string_end);
			if (!in_bus.valid || in_bus.ready) begin
				if (idle_left != 0) begin
					idle_left <= idle_left - 1;
					in_bus.valid <= 1'b0;
				end else if (pending_codes.size() == 0) begin
					in_bus.valid <= 1'b0;
				end else if (pending_codes[0].gap != 0) begin
					idle_left <= pending_codes[0].gap - 1;
					pending_codes[0].gap = 0;
					in_bus.valid <= 1'b0;
				end else if (pending_codes[0].drain && expected_chars.size() != 0) begin
					in_bus.valid <= 1'b0;
				end else begin
					next_code = pending_codes.pop_front();
					in_bus.valid <= 1'b1;
					in_bus.code_byte <= next_code.code;
					in_bus.string_end <= next_code.last;
				end
			end
		end
	end

	// stall-free windows alternate with windows of random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_bus.ready <= 1'b0;
		end else begin
			out_bus.ready <= 1'b1;
			if (cycle_count % 1024 >= 256 && $urandom_range(0, 3) == 0)
				stall_left <= pick_idle();
		end
	end

	always @(posedge clk) begin
		char_result_t want;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected character transfer: char_out %h", out_bus.char_out);
				failures++;
			end else begin
				want = expected_chars.pop_front();
				chars_checked++;
				if (out_bus.char_out !== want.ch) begin
					$error("char_out: expected %h, got %h", want.ch, out_bus.char_out);
					failures++;
				end
				if (out_bus.run_last !== want.run_last) begin
					$error("run_last: expected %b, got %b", want.run_last, out_bus.run_last);
					failures++;
				end
				if (out_bus.text_end !== want.text_end) begin
					$error("text_end: expected %b, got %b", want.text_end, out_bus.text_end);
					failures++;
				end
				if (out_bus.escape_error !== want.escape_error) begin
					$error("escape_error: expected %b, got %b", want.escape_error,
						out_bus.escape_error);
					failures++;
				end
			end
		end
	end

	initial begin
		int unsigned len;
		int unsigned pick;
		logic        calm;
		logic        noise;
		logic        any_next;
		logic        first;
		logic        last;
		logic [7:0]  code;

		in_bus.valid = 1'b0;
		in_bus.code_byte = 8'h00;
		in_bus.string_end = 1'b0;
		out_bus.ready = 1'b0;
		escape_armed = 1'b0;
		cycle_count = 0;
		failures = 0;
		codes_sent = 0;
		strings_sent = 0;
		chars_checked = 0;
		digrams_seen = 0;
		escape_errors = 0;

		add_code(8'h00, 1'b0, 0, 1'b0);
		add_code(8'h7F, 1'b0, 0, 1'b0);
		add_code(CR_CODE, 1'b0, 0, 1'b0);
		add_code(FF_CODE, 1'b0, 0, 1'b0);
		add_code(PERIOD_CODE, 1'b1, 0, 1'b0);
		add_code(8'h80, 1'b0, 0, 1'b0);
		add_code(8'hFF, 1'b1, 0, 1'b0);
		add_code(8'hC5, 1'b1, 2, 1'b0);
		add_code(ESCAPE_CODE, 1'b0, 0, 1'b0);
		add_code(8'h00, 1'b0, 0, 1'b0);
		add_code(ESCAPE_CODE, 1'b0, 0, 1'b0);
		add_code(8'hFF, 1'b0, 0, 1'b0);
		add_code(ESCAPE_CODE, 1'b0, 0, 1'b0);
		add_code(ESCAPE_CODE, 1'b0, 0, 1'b0);
		add_code(ESCAPE_CODE, 1'b0, 1, 1'b0);
		add_code(8'h81, 1'b1, 0, 1'b0);
		add_code(ESCAPE_CODE, 1'b0, 0, 1'b0);
		add_code(CR_CODE, 1'b1, 0, 1'b0);
		add_code(ESCAPE_CODE, 1'b1, 0, 1'b0);
		add_code(8'h41, 1'b0, 0, 1'b0);
		add_code(ESCAPE_CODE, 1'b1, 0, 1'b0);
		add_code(8'h20, 1'b1, 0, 1'b0);

		// well-formed strings with random content, a few noisy end flags
		first = 1'b1;
		while (pending_codes.size() < CODE_TARGET) begin
			len = $urandom_range(1, 12);
			calm = $urandom_range(0, 9) < 3;
			noise = $urandom_range(0, 19) == 0;
			any_next = 1'b0;
			for (int i = 0; i < len; i++) begin
				pick = $urandom_range(0, 99);
				if (any_next || pick >= 92) begin
					code = 8'($urandom_range(0, 255));
				end else if (pick < 45) begin
					code = 8'h80 | 8'($urandom_range(0, 127));
				end else if (pick < 72) begin
					code = 8'($urandom_range(8'h20, 8'h7E));
				end else if (pick < 82) begin
					case ($urandom_range(0, 3))
						0: code = CR_CODE;
						1: code = FF_CODE;
						2: code = PERIOD_CODE;
						default: code = 8'h00;
					endcase
				end else begin
					code = ESCAPE_CODE;
				end
				any_next = (code == ESCAPE_CODE) && !any_next;
				last = noise ? 1'($urandom_range(0, 1)) : (i == len - 1);
				add_code(code, last, calm ? 0 : pick_idle(),
					first || $urandom_range(0, 149) == 0);
				first = 1'b0;
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do
			@(posedge clk);
		while (pending_codes.size() != 0 || in_bus.valid || expected_chars.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (expected_chars.size() != 0) begin
			$error("%0d expected characters never arrived", expected_chars.size());
			failures++;
		end
		$display("sent %0d code bytes in %0d strings over %0d cycles", codes_sent,
			strings_sent, cycle_count);
		$display("checked %0d characters: %0d digram bytes, %0d trailing escapes",
			chars_checked, digrams_seen, escape_errors);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
